[sv/mbg_pkg.sv]
`default_nettype none
package mbg_pkg;

  localparam int MBG_GRID_SIDE = 16;

  localparam int COORD_W   = 4;
  localparam int MASK_W    = 4;
  localparam int OP_W      = 2;
  localparam int DIR_BITS  = 2;
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int DEPTH_W   = ADDR_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_E = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  // Source of the cell store read address
  typedef enum logic [1:0] {
    RD_REQ = 2'd0,
    RD_NB  = 2'd1,
    RD_TOP = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    start;
    logic    res_zero;
    logic    res_read;
    logic    res_top;
    logic    res_carve;
    logic    stk_read;
    logic    load_top;
    logic    dir_inc;
    logic    dir_choice;
    logic    pop;
    logic    push;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_top;
    logic    wr_nb;
    logic    out_load;
  } mbg_cmd_t;

  typedef struct packed {
    logic depth_zero;
    logic nb_ok;
    logic mask_zero;
    logic dir_last;
  } mbg_sts_t;

  // Passage bit on the cell we leave from
  function automatic logic [MASK_W-1:0] here_bit(input dir_t d);
    here_bit = MASK_W'(1) << d;
  endfunction

  // Passage bit on the cell we enter
  function automatic logic [MASK_W-1:0] there_bit(input dir_t d);
    there_bit = MASK_W'(1) << (d ^ 2'd1);
  endfunction

endpackage
`default_nettype wire

[sv/mbg_dp.sv]
`default_nettype none
module mbg_dp
  import mbg_pkg::*;
#(
  parameter int GRID_SIDE = MBG_GRID_SIDE
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mbg_cmd_t              cmd,
  output mbg_sts_t                   sts,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [DIR_BITS-1:0]   in_choice,
  input  wire logic [COORD_W-1:0]    in_read_x,
  input  wire logic [COORD_W-1:0]    in_read_y,
  output logic                       out_carved,
  output logic [COORD_W-1:0]         out_cell_x,
  output logic [COORD_W-1:0]         out_cell_y,
  output logic [MASK_W-1:0]          out_cell_mask,
  output logic                       out_finished
);

  localparam logic [COORD_W:0]   SIDE = (COORD_W + 1)'(GRID_SIDE);
  localparam logic [COORD_W-1:0] LAST = COORD_W'(GRID_SIDE - 1);

  logic [COORD_W-1:0] start_x_r, start_y_r;
  logic [DIR_BITS-1:0] choice_r;
  logic [COORD_W-1:0] rx_r, ry_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [COORD_W-1:0] top_x_r, top_y_r;
  dir_t               dir_r;

  logic [MASK_W-1:0]  cell_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [MASK_W-1:0]  cell_q_r;
  logic               vld_q_r;
  logic [ADDR_W-1:0]  stk_mem [MEM_DEPTH];
  logic [ADDR_W-1:0]  stk_q_r;

  logic               res_carved_r;
  logic [COORD_W-1:0] res_x_r, res_y_r;
  logic [MASK_W-1:0]  res_mask_r;

  logic [COORD_W-1:0] sx, sy;
  logic [COORD_W-1:0] nb_x, nb_y;
  logic               nb_ok;
  logic [MASK_W-1:0]  mask_rd;
  logic               read_in_grid;
  logic [ADDR_W-1:0]  rd_addr, wr_addr, stk_wr_addr, stk_wr_data, stk_rd_addr;
  logic [DEPTH_W-1:0] depth_m1;
  logic [MASK_W-1:0]  wr_data;
  logic               wr_en, stk_we;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_X: start_x_r <= cfg_wdata;
        CFG_START_Y: start_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sx = ({1'b0, start_x_r} >= SIDE) ? LAST : start_x_r;
  assign sy = ({1'b0, start_y_r} >= SIDE) ? LAST : start_y_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      choice_r <= in_choice;
      rx_r     <= in_read_x;
      ry_r     <= in_read_y;
    end
  end

  // Neighbor of the top cell in the current direction
  always_comb begin
    nb_x  = top_x_r;
    nb_y  = top_y_r;
    nb_ok = 1'b0;
    unique case (dir_r)
      DIR_N: begin
        nb_ok = (top_y_r != '0);
        nb_y  = top_y_r - COORD_W'(1);
      end
      DIR_S: begin
        nb_ok = (({1'b0, top_y_r} + (COORD_W + 1)'(1)) < SIDE);
        nb_y  = top_y_r + COORD_W'(1);
      end
      DIR_E: begin
        nb_ok = (({1'b0, top_x_r} + (COORD_W + 1)'(1)) < SIDE);
        nb_x  = top_x_r + COORD_W'(1);
      end
      DIR_W: begin
        nb_ok = (top_x_r != '0);
        nb_x  = top_x_r - COORD_W'(1);
      end
      default: ;
    endcase
  end

  assign mask_rd      = vld_q_r ? cell_q_r : '0;
  assign read_in_grid = ({1'b0, rx_r} < SIDE) && ({1'b0, ry_r} < SIDE);

  // Cell store: one read and one write port, registered read data
  always_comb begin
    unique case (cmd.rd_sel)
      RD_REQ:  rd_addr = {ry_r, rx_r};
      RD_NB:   rd_addr = {nb_y, nb_x};
      RD_TOP:  rd_addr = {top_y_r, top_x_r};
      default: rd_addr = {top_y_r, top_x_r};
    endcase
  end

  assign wr_en   = cmd.wr_top | cmd.wr_nb;
  assign wr_addr = cmd.wr_nb ? {nb_y, nb_x} : {top_y_r, top_x_r};
  assign wr_data = cmd.wr_nb ? there_bit(dir_r) : (mask_rd | here_bit(dir_r));

  always_ff @(posedge clk) begin
    if (wr_en) cell_mem[wr_addr] <= wr_data;
    if (cmd.rd_en) cell_q_r <= cell_mem[rd_addr];
  end

  // Entries not written since the last start read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (cmd.start) vld_r <= '0;
      else if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (cmd.rd_en) vld_q_r <= vld_r[rd_addr];
    end
  end

  // Path stack
  assign depth_m1    = depth_r - DEPTH_W'(1);
  assign stk_rd_addr = depth_m1[ADDR_W-1:0];
  assign stk_we      = cmd.start | (cmd.push & ~depth_r[DEPTH_W-1]);
  assign stk_wr_addr = cmd.start ? '0 : depth_r[ADDR_W-1:0];
  assign stk_wr_data = cmd.start ? {sy, sx} : {nb_y, nb_x};

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wr_addr] <= stk_wr_data;
    if (cmd.stk_read) stk_q_r <= stk_mem[stk_rd_addr];
  end

  always_comb begin
    depth_nxt = depth_r;
    if (cmd.start) depth_nxt = DEPTH_W'(1);
    else if (cmd.pop) depth_nxt = depth_m1;
    else if (cmd.push && !depth_r[DEPTH_W-1]) depth_nxt = depth_r + DEPTH_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) depth_r <= '0;
    else depth_r <= depth_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_top) begin
      top_x_r <= stk_q_r[COORD_W-1:0];
      top_y_r <= stk_q_r[ADDR_W-1:COORD_W];
    end
    if (cmd.load_top) dir_r <= DIR_N;
    else if (cmd.dir_choice) dir_r <= dir_t'(choice_r);
    else if (cmd.dir_inc) dir_r <= dir_t'(dir_r + DIR_BITS'(1));
  end

  // Result holding registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_carved_r <= 1'b0;
      res_x_r      <= sx;
      res_y_r      <= sy;
      res_mask_r   <= '0;
    end else if (cmd.res_zero) begin
      res_carved_r <= 1'b0;
      res_x_r      <= '0;
      res_y_r      <= '0;
      res_mask_r   <= '0;
    end else if (cmd.res_read) begin
      res_carved_r <= 1'b0;
      res_x_r      <= rx_r;
      res_y_r      <= ry_r;
      res_mask_r   <= read_in_grid ? mask_rd : '0;
    end else if (cmd.res_top) begin
      res_carved_r <= 1'b0;
      res_x_r      <= top_x_r;
      res_y_r      <= top_y_r;
      res_mask_r   <= mask_rd;
    end else if (cmd.res_carve) begin
      res_carved_r <= 1'b1;
      res_x_r      <= nb_x;
      res_y_r      <= nb_y;
      res_mask_r   <= there_bit(dir_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_carved    <= res_carved_r;
      out_cell_x    <= res_x_r;
      out_cell_y    <= res_y_r;
      out_cell_mask <= res_mask_r;
      out_finished  <= (depth_r == '0);
    end
  end

  assign sts.depth_zero = (depth_r == '0);
  assign sts.nb_ok      = nb_ok;
  assign sts.mask_zero  = (mask_rd == '0);
  assign sts.dir_last   = (dir_r == DIR_W);

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MEM_DEPTH))
    else $error("stack depth beyond store size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (depth_r != '0) ##1 (depth_r == $past(depth_r) - DEPTH_W'(1)))
    else $error("pop from empty stack or depth not decremented");

  a_carve_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_nb || cmd.push) |-> nb_ok)
    else $error("carve toward a cell outside the grid");
`endif

endmodule
`default_nettype wire

[sv/mbg_ctrl.sv]
`default_nettype none
module mbg_ctrl
  import mbg_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [OP_W-1:0] in_operation,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire mbg_sts_t        sts,
  output mbg_cmd_t             cmd
);

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_START    = 16'h0002,
    ST_NONE     = 16'h0004,
    ST_READ_REQ = 16'h0008,
    ST_READ_DAT = 16'h0010,
    ST_POP_CHK  = 16'h0020,
    ST_TOP      = 16'h0040,
    ST_SCAN     = 16'h0080,
    ST_SCAN_DAT = 16'h0100,
    ST_POP      = 16'h0200,
    ST_CH_REQ   = 16'h0400,
    ST_CH_DAT   = 16'h0800,
    ST_CARVE    = 16'h1000,
    ST_CARVE_NB = 16'h2000,
    ST_TOP_DAT  = 16'h4000,
    ST_OUT      = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = RD_TOP;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (op_t'(in_operation))
            OP_START: state_nxt = ST_START;
            OP_STEP:  state_nxt = ST_POP_CHK;
            OP_READ:  state_nxt = ST_READ_REQ;
            default:  state_nxt = ST_NONE;
          endcase
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_NONE: begin
        cmd.res_zero = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_READ_REQ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_REQ;
        state_nxt  = ST_READ_DAT;
      end
      ST_READ_DAT: begin
        cmd.res_read = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_POP_CHK: begin
        if (sts.depth_zero) begin
          cmd.res_zero = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          cmd.stk_read = 1'b1;
          state_nxt    = ST_TOP;
        end
      end
      ST_TOP: begin
        cmd.load_top = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.nb_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NB;
          state_nxt  = ST_SCAN_DAT;
        end else if (sts.dir_last) begin
          state_nxt = ST_POP;
        end else begin
          cmd.dir_inc = 1'b1;
        end
      end
      ST_SCAN_DAT: begin
        if (sts.mask_zero) begin
          cmd.dir_choice = 1'b1;
          state_nxt      = ST_CH_REQ;
        end else if (sts.dir_last) begin
          state_nxt = ST_POP;
        end else begin
          cmd.dir_inc = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_POP_CHK;
      end
      ST_CH_REQ: begin
        cmd.rd_en = 1'b1;
        if (sts.nb_ok) begin
          cmd.rd_sel = RD_NB;
          state_nxt  = ST_CH_DAT;
        end else begin
          state_nxt = ST_TOP_DAT;
        end
      end
      ST_CH_DAT: begin
        cmd.rd_en = 1'b1;
        state_nxt = sts.mask_zero ? ST_CARVE : ST_TOP_DAT;
      end
      ST_CARVE: begin
        cmd.wr_top = 1'b1;
        cmd.push   = 1'b1;
        state_nxt  = ST_CARVE_NB;
      end
      ST_CARVE_NB: begin
        cmd.wr_nb     = 1'b1;
        cmd.res_carve = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_TOP_DAT: begin
        cmd.res_top = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("accepted item left no work in progress");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

[sv/maze_backtracker_generator_top.sv]
`default_nettype none
// Depth-first maze carver over a GRID_SIDE x GRID_SIDE grid of 4-bit passage
// masks (N=1, S=2, E=4, W=8), one result transfer per input transfer. On a
// start the cell store is cleared at once through per-entry valid flops, so
// there is no clearing pass. A step fetches each examined stack top, then
// reads each in-grid neighbor it probes and skips each off-grid direction,
// pops each dead end, and last tries the chosen direction and carves. The
// cell store has a single read port: every neighbor probe is one memory
// read. The block takes a new item once the previous result sits in the
// output register; the result waits there until the consumer drops stall.
module maze_backtracker_generator_top
  import mbg_pkg::*;
#(
  parameter int GRID_SIDE = MBG_GRID_SIDE
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [OP_W-1:0]       in_operation,
  input  wire logic [DIR_BITS-1:0]   in_choice,
  input  wire logic [COORD_W-1:0]    in_read_x,
  input  wire logic [COORD_W-1:0]    in_read_y,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_carved,
  output logic [COORD_W-1:0]         out_cell_x,
  output logic [COORD_W-1:0]         out_cell_y,
  output logic [MASK_W-1:0]          out_cell_mask,
  output logic                       out_finished
);

  mbg_cmd_t cmd;
  mbg_sts_t sts;

  // Sequencer: walks the stack, probes neighbors, orders the carve writes
  mbg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Cell store, path stack, coordinates and the output register
  mbg_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_choice     (in_choice),
    .in_read_x     (in_read_x),
    .in_read_y     (in_read_y),
    .out_carved    (out_carved),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_cell_mask (out_cell_mask),
    .out_finished  (out_finished)
  );

endmodule
`default_nettype wire

[sim/maze_backtracker_generator_top_test.sv]
`timescale 1ns / 100ps

module maze_backtracker_generator_top_test
  import mbg_pkg::*;
;

  localparam int SIDE = MBG_GRID_SIDE;

  // Operation code outside the defined set; the block must answer it without
  // touching the maze.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int HOLD_AFTER     = 200;  // results seen before the long hold-off
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic               carved;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [MASK_W-1:0]  mask;
    logic               finished;
  } maze_result_t;

  // One line of the directed table: either a start-cell setting or an item,
  // with a hand-written result where it is obvious.
  typedef struct packed {
    logic               is_cfg;
    logic [COORD_W-1:0] cfg_col;
    logic [COORD_W-1:0] cfg_row;
    logic [OP_W-1:0]    op;
    dir_t               dir;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               typed;
    maze_result_t       want;
  } probe_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation;
  logic [DIR_BITS-1:0]   in_choice;
  logic [COORD_W-1:0]    in_read_x;
  logic [COORD_W-1:0]    in_read_y;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_carved;
  logic [COORD_W-1:0]    out_cell_x;
  logic [COORD_W-1:0]    out_cell_y;
  logic [MASK_W-1:0]     out_cell_mask;
  logic                  out_finished;

  maze_backtracker_generator_top #(.GRID_SIDE(SIDE)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_choice     (in_choice),
    .in_read_x     (in_read_x),
    .in_read_y     (in_read_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_carved    (out_carved),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_cell_mask (out_cell_mask),
    .out_finished  (out_finished)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Maze predictor: its own copy of the grid, the path stack and the start cell.
  // ---------------------------------------------------------------------------
  logic [MASK_W-1:0]  maze_cells [MEM_DEPTH];
  logic [ADDR_W-1:0]  trail      [MEM_DEPTH];
  int unsigned        trail_depth = 0;
  logic [COORD_W-1:0] start_col   = '0;
  logic [COORD_W-1:0] start_row   = '0;

  maze_result_t expected_results [$];

  // Bookkeeping for the closing summary
  int mismatches     = 0;
  int results_seen   = 0;
  int items_done     = 0;
  int starts_done    = 0;
  int steps_done     = 0;
  int carves_done    = 0;
  int reads_done     = 0;
  int unused_done    = 0;
  int mazes_done     = 0;
  int settings_done  = 0;
  int deepest        = 0;
  int stalled_inputs = 0;
  bit idle_on        = 1'b1;
  bit hold_done      = 1'b0;

  initial begin
    foreach (maze_cells[i]) maze_cells[i] = '0;
    foreach (trail[i]) trail[i] = '0;
  end

  function automatic logic [MASK_W-1:0] passage(input dir_t d);
    case (d)
      DIR_N:   return 4'b0001;
      DIR_S:   return 4'b0010;
      DIR_E:   return 4'b0100;
      default: return 4'b1000;
    endcase
  endfunction

  function automatic dir_t reverse(input dir_t d);
    case (d)
      DIR_N:   return DIR_S;
      DIR_S:   return DIR_N;
      DIR_E:   return DIR_W;
      default: return DIR_E;
    endcase
  endfunction

  // Cell one move away; 0 when the move leaves the grid.
  function automatic bit step_to(input int col, input int row, input dir_t d,
                                 output int ncol, output int nrow);
    ncol = col;
    nrow = row;
    case (d)
      DIR_N: begin
        if (row == 0) return 1'b0;
        nrow = row - 1;
      end
      DIR_S: begin
        if (row + 1 >= SIDE) return 1'b0;
        nrow = row + 1;
      end
      DIR_E: begin
        if (col + 1 >= SIDE) return 1'b0;
        ncol = col + 1;
      end
      default: begin
        if (col == 0) return 1'b0;
        ncol = col - 1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic bit fresh_around(input int col, input int row);
    int nc, nr;
    for (int d = 0; d < 4; d++)
      if (step_to(col, row, dir_t'(d), nc, nr) && maze_cells[{nr[3:0], nc[3:0]}] == '0)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v >= SIDE) ? SIDE - 1 : v;
  endfunction

  // Apply one accepted item to the predicted maze and return its result.
  function automatic maze_result_t carve_predict(input logic [OP_W-1:0] op, input dir_t d,
                                                 input logic [COORD_W-1:0] rc,
                                                 input logic [COORD_W-1:0] rr);
    maze_result_t res;
    int col, row, nc, nr;
    logic [ADDR_W-1:0] top;
    bit was_busy;
    res = '0;
    case (op)
      OP_START: begin
        starts_done++;
        foreach (maze_cells[i]) maze_cells[i] = '0;
        col = clamp_coord(start_col);
        row = clamp_coord(start_row);
        trail[0] = {row[3:0], col[3:0]};
        trail_depth = 1;
        res.x = col[3:0];
        res.y = row[3:0];
      end
      OP_STEP: begin
        steps_done++;
        was_busy = (trail_depth != 0);
        // Drop dead ends off the top of the path first
        while (trail_depth > 0 &&
               !fresh_around(trail[trail_depth-1][3:0], trail[trail_depth-1][7:4]))
          trail_depth--;
        if (trail_depth > 0) begin
          top = trail[trail_depth-1];
          col = top[3:0];
          row = top[7:4];
          if (step_to(col, row, d, nc, nr) && maze_cells[{nr[3:0], nc[3:0]}] == '0) begin
            maze_cells[{row[3:0], col[3:0]}] |= passage(d);
            maze_cells[{nr[3:0], nc[3:0]}]   |= passage(reverse(d));
            if (trail_depth < MEM_DEPTH) begin
              trail[trail_depth] = {nr[3:0], nc[3:0]};
              trail_depth++;
            end
            if (trail_depth > deepest) deepest = trail_depth;
            carves_done++;
            res.carved = 1'b1;
            col = nc;
            row = nr;
          end
          res.x    = col[3:0];
          res.y    = row[3:0];
          res.mask = maze_cells[{row[3:0], col[3:0]}];
        end else if (was_busy) begin
          mazes_done++;
        end
      end
      OP_READ: begin
        reads_done++;
        res.x = rc;
        res.y = rr;
        if (rc < SIDE && rr < SIDE) res.mask = maze_cells[{rr, rc}];
      end
      default: unused_done++;
    endcase
    res.finished = (trail_depth == 0);
    return res;
  endfunction

  // Pick a direction that carves from the cell that will be on top once the
  // dead ends are gone, so that mazes grow deep and finish.
  function automatic dir_t steer_choice();
    int depth_left, col, row, nc, nr;
    dir_t open_dirs [$];
    depth_left = trail_depth;
    while (depth_left > 0 &&
           !fresh_around(trail[depth_left-1][3:0], trail[depth_left-1][7:4]))
      depth_left--;
    if (depth_left == 0) return dir_t'($urandom_range(0, 3));
    col = trail[depth_left-1][3:0];
    row = trail[depth_left-1][7:4];
    for (int d = 0; d < 4; d++)
      if (step_to(col, row, dir_t'(d), nc, nr) && maze_cells[{nr[3:0], nc[3:0]}] == '0)
        open_dirs.push_back(dir_t'(d));
    return open_dirs[$urandom_range(0, open_dirs.size() - 1)];
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic maze_result_t outcome(input int c, input int x, input int y,
                                           input int m, input int f);
    maze_result_t res;
    res.carved   = c[0];
    res.x        = x[3:0];
    res.y        = y[3:0];
    res.mask     = m[3:0];
    res.finished = f[0];
    return res;
  endfunction

  function automatic probe_row_t item_row(input logic [OP_W-1:0] op, input dir_t d,
                                          input logic [3:0] c, input logic [3:0] r);
    probe_row_t p;
    p = '0;
    p.op  = op;
    p.dir = d;
    p.col = c;
    p.row = r;
    return p;
  endfunction

  function automatic probe_row_t known_row(input logic [OP_W-1:0] op, input dir_t d,
                                           input logic [3:0] c, input logic [3:0] r,
                                           input maze_result_t want);
    probe_row_t p;
    p = item_row(op, d, c, r);
    p.typed = 1'b1;
    p.want  = want;
    return p;
  endfunction

  function automatic probe_row_t cfg_row(input logic [3:0] c, input logic [3:0] r);
    probe_row_t p;
    p = '0;
    p.is_cfg  = 1'b1;
    p.cfg_col = c;
    p.cfg_row = r;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
  endtask

  // Sample at the edge; every value read here is the one the edge transfers.
  always @(posedge clk) begin
    maze_result_t want;
    if (rst_n) begin
      if (in_valid && in_stall) stalled_inputs++;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_carved !== want.carved)     flag_mismatch("carved", out_carved, want.carved);
          if (out_cell_x !== want.x)          flag_mismatch("cell_x", out_cell_x, want.x);
          if (out_cell_y !== want.y)          flag_mismatch("cell_y", out_cell_y, want.y);
          if (out_cell_mask !== want.mask)    flag_mismatch("cell_mask", out_cell_mask, want.mask);
          if (out_finished !== want.finished) flag_mismatch("finished", out_finished, want.finished);
        end
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall, one long hold-off to back the block up.
  // ---------------------------------------------------------------------------
  initial begin : consumer
    int run;
    out_stall = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        // Hold the result channel while the sender keeps offering items
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on) begin
        run = idle_len();
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then predict its result.
  // Predicting here keeps the model current before the next item is chosen.
  task automatic offer_item(input logic [OP_W-1:0] op, input dir_t d,
                            input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input logic typed, input maze_result_t want);
    int gap;
    maze_result_t res;
    gap = idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_choice    <= d;
    in_read_x    <= col;
    in_read_y    <= row;
    do @(posedge clk); while (in_stall);
    res = carve_predict(op, d, col, row);
    expected_results.push_back(typed ? want : res);
    items_done++;
  endtask

  // Drop valid and let every pending result drain, so the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both start registers on back-to-back edges.
  task automatic load_start(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_X;
    cfg_wdata <= col;
    @(posedge clk);
    cfg_index <= CFG_START_Y;
    cfg_wdata <= row;
    @(posedge clk);
    cfg_we    <= 1'b0;
    start_col = col;
    start_row = row;
    settings_done++;
  endtask

  initial begin : producer
    probe_row_t probe_rows [$];
    logic [OP_W-1:0] op;
    dir_t d;
    logic [COORD_W-1:0] col, row;
    bit full_run;
    int phase_len, phase_items, pick, steer_pct;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_choice    = '0;
    in_read_x    = '0;
    in_read_y    = '0;

    // Directed table: empty-stack answers after reset, the four corners as
    // start cells, moves off each edge, reads at the grid extremes and the
    // unused operation code. Rows without a typed result go to the predictor.
    probe_rows.push_back(known_row(OP_STEP,   DIR_E, 4'd0,  4'd0,  outcome(0, 0, 0, 0, 1)));
    probe_rows.push_back(known_row(OP_UNUSED, DIR_W, 4'd15, 4'd15, outcome(0, 0, 0, 0, 1)));
    probe_rows.push_back(known_row(OP_READ,   DIR_N, 4'd0,  4'd0,  outcome(0, 0, 0, 0, 1)));
    probe_rows.push_back(known_row(OP_READ,   DIR_S, 4'd15, 4'd15, outcome(0, 15, 15, 0, 1)));
    probe_rows.push_back(known_row(OP_START,  DIR_N, 4'd15, 4'd0,  outcome(0, 0, 0, 0, 0)));
    probe_rows.push_back(known_row(OP_STEP,   DIR_N, 4'd0,  4'd0,  outcome(0, 0, 0, 0, 0)));
    probe_rows.push_back(known_row(OP_STEP,   DIR_W, 4'd0,  4'd0,  outcome(0, 0, 0, 0, 0)));
    probe_rows.push_back(item_row(OP_STEP, DIR_S, 4'd0, 4'd0));
    probe_rows.push_back(item_row(OP_STEP, DIR_N, 4'd0, 4'd0));
    probe_rows.push_back(item_row(OP_STEP, DIR_E, 4'd0, 4'd0));
    probe_rows.push_back(item_row(OP_READ, DIR_N, 4'd0, 4'd0));
    probe_rows.push_back(item_row(OP_READ, DIR_N, 4'd0, 4'd15));
    probe_rows.push_back(known_row(OP_UNUSED, DIR_S, 4'd9, 4'd6, outcome(0, 0, 0, 0, 0)));
    probe_rows.push_back(cfg_row(4'd15, 4'd15));
    probe_rows.push_back(known_row(OP_START,  DIR_E, 4'd0,  4'd0,  outcome(0, 15, 15, 0, 0)));
    probe_rows.push_back(known_row(OP_STEP,   DIR_S, 4'd0,  4'd0,  outcome(0, 15, 15, 0, 0)));
    probe_rows.push_back(known_row(OP_STEP,   DIR_E, 4'd0,  4'd0,  outcome(0, 15, 15, 0, 0)));
    probe_rows.push_back(item_row(OP_STEP, DIR_N, 4'd0, 4'd0));
    probe_rows.push_back(item_row(OP_STEP, DIR_W, 4'd0, 4'd0));
    probe_rows.push_back(item_row(OP_READ, DIR_N, 4'd15, 4'd0));
    probe_rows.push_back(cfg_row(4'd0, 4'd15));
    probe_rows.push_back(known_row(OP_START,  DIR_S, 4'd0,  4'd0,  outcome(0, 0, 15, 0, 0)));
    probe_rows.push_back(known_row(OP_STEP,   DIR_W, 4'd0,  4'd0,  outcome(0, 0, 15, 0, 0)));
    probe_rows.push_back(item_row(OP_STEP, DIR_E, 4'd0, 4'd0));
    probe_rows.push_back(item_row(OP_STEP, DIR_S, 4'd0, 4'd0));
    probe_rows.push_back(cfg_row(4'd15, 4'd0));
    probe_rows.push_back(known_row(OP_START,  DIR_W, 4'd0,  4'd0,  outcome(0, 15, 0, 0, 0)));
    probe_rows.push_back(known_row(OP_STEP,   DIR_N, 4'd0,  4'd0,  outcome(0, 15, 0, 0, 0)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[i]) begin
      if (probe_rows[i].is_cfg) begin
        settle();
        load_start(probe_rows[i].cfg_col, probe_rows[i].cfg_row);
      end else begin
        offer_item(probe_rows[i].op, probe_rows[i].dir, probe_rows[i].col,
                   probe_rows[i].row, probe_rows[i].typed, probe_rows[i].want);
      end
    end

    // Random phases: each picks a start cell (corners often), then carves.
    // Full phases steer almost every step so the maze completes and the tail
    // exercises long backtracks and steps on an empty stack; short phases
    // mix in restarts, reads and the unused code.
    while (items_done < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 9);
      case (pick)
        0: load_start(4'd0, 4'd0);
        1: load_start(4'd15, 4'd15);
        2: load_start(4'd0, 4'd15);
        3: load_start(4'd15, 4'd0);
        default: load_start(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      idle_on   = ($urandom_range(0, 3) != 0);
      full_run  = ($urandom_range(0, 1) == 1);
      phase_len = full_run ? $urandom_range(330, 380) : $urandom_range(40, 200);
      steer_pct = full_run ? 97 : 75;
      offer_item(OP_START, dir_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)), 1'b0, '0);
      phase_items = 1;
      while (phase_items < phase_len && items_done < DIRECTED_ITEMS + RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 2)                               op = OP_UNUSED;
        else if (!full_run && pick < 5)             op = OP_START;
        else if (pick < (full_run ? 10 : 22))       op = OP_READ;
        else                                        op = OP_STEP;
        if (op == OP_STEP && $urandom_range(0, 99) < steer_pct) d = steer_choice();
        else d = dir_t'($urandom_range(0, 3));
        col = 4'($urandom_range(0, 15));
        row = 4'($urandom_range(0, 15));
        offer_item(op, d, col, row, 1'b0, '0);
        phase_items++;
      end
    end

    // Drain, then keep watching so that any stray result shows
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (expected_results.size() != 0)
      flag_mismatch("results never delivered", expected_results.size(), 0);

    $display("covered %0d items: %0d starts, %0d steps (%0d carved), %0d reads, %0d unused code",
             items_done, starts_done, steps_done, carves_done, reads_done, unused_done);
    $display("%0d mazes completed over %0d start settings, deepest path %0d, %0d input stalls",
             mazes_done, settings_done, deepest, stalled_inputs);
    if (mismatches == 0) begin
      $display("maze_backtracker_generator_top_test: clean");
    end else begin
      $display("maze_backtracker_generator_top_test: errors");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    #2000000;
    $display("maze_backtracker_generator_top_test: errors");
    $finish;
  end

endmodule
